// File: hw/rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// shared types, codes and defaults of the keypad press classifier
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int ROWS_DEF  = 4;
    localparam int COLS_DEF  = 3;
    localparam int LEVEL_W   = 3;
    localparam int COUNT_W   = 8;
    localparam int KEY_OUT_W = 4;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] LONG_THR_RST  = 8'd25;
    localparam logic [COUNT_W-1:0] SHORT_THR_RST = 8'd10;
    localparam logic [COUNT_W-1:0] LONG_DEV_RST  = 8'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_DEV  = 2'd2;

    localparam logic [KIND_W-1:0] EV_SHORT        = 2'd0;
    localparam logic [KIND_W-1:0] EV_DOUBLE_SHORT = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONG         = 2'd2;
    localparam logic [KIND_W-1:0] EV_DOUBLE_LONG  = 2'd3;

    typedef enum logic [1:0] {
        CMP_SHORT,
        CMP_LONG_EQ,
        CMP_DOUBLE_LONG
    } cmp_op_t;

    typedef struct packed {
        logic [COUNT_W-1:0] long_thr;
        logic [COUNT_W-1:0] short_thr;
        logic [COUNT_W-1:0] long_dev;
    } cfg_t;

endpackage

// File: hw/rtl/keypad_press_classifier.sv
// ----------------------------------------------------------------------------
// keypad_press_classifier
// classifies matrix keypad scan samples into short, double short, long and
// double long press events
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  s_        s_valid / s_ready      s_row, s_column_levels
//  m_        m_valid / m_ready      m_event_kind, m_first_key, m_second_key, m_last
//  cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  a sample is worked through column by column, and each column whose counter
//  triggers a search also walks the counter store; the single read port of the
//  counter store sets the search length
//  s_ready is high only between samples; out-of-range rows are dropped at once
//  events leave through an output register, the sequencer waits on m_ready
//  counters are cleared at reset by per-key valid bits, no clearing pass
// ----------------------------------------------------------------------------
module keypad_press_classifier #(
    parameter int ROWS = kpc_pkg::ROWS_DEF,
    parameter int COLS = kpc_pkg::COLS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kpc_pkg::COUNT_W-1:0]          cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_row,
    input  logic [kpc_pkg::LEVEL_W-1:0]          s_column_levels,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [kpc_pkg::KIND_W-1:0]           m_event_kind,
    output logic [kpc_pkg::KEY_OUT_W-1:0]        m_first_key,
    output logic [kpc_pkg::KEY_OUT_W-1:0]        m_second_key,
    output logic                                 m_last
);

    kpc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_thr  <= kpc_pkg::LONG_THR_RST;
            cfg_reg.short_thr <= kpc_pkg::SHORT_THR_RST;
            cfg_reg.long_dev  <= kpc_pkg::LONG_DEV_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                kpc_pkg::CFG_LONG_THR:  cfg_reg.long_thr  <= cfg_data;
                kpc_pkg::CFG_SHORT_THR: cfg_reg.short_thr <= cfg_data;
                kpc_pkg::CFG_LONG_DEV:  cfg_reg.long_dev  <= cfg_data;
                default: ;
            endcase
        end
    end

    kpc_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row           (s_row),
        .s_column_levels (s_column_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_first_key     (m_first_key),
        .m_second_key    (m_second_key),
        .m_last          (m_last)
    );

endmodule

// File: hw/rtl/kpc_ram.sv
// ----------------------------------------------------------------------------
// kpc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module kpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/kpc_cmp.sv
// ----------------------------------------------------------------------------
// kpc_cmp
// shared count comparator for long, double long and short range checks
// ----------------------------------------------------------------------------
module kpc_cmp (
    input  logic [kpc_pkg::COUNT_W-1:0] value,
    input  kpc_pkg::cmp_op_t            op,
    input  kpc_pkg::cfg_t               cfg,
    output logic                        match
);

    logic [kpc_pkg::COUNT_W:0] sum;

    // value >= long_thr - long_dev, without going negative
    assign sum = {1'b0, value} + {1'b0, cfg.long_dev};

    always_comb begin
        case (op)
            kpc_pkg::CMP_SHORT:       match = (value != '0) && (value < cfg.short_thr);
            kpc_pkg::CMP_LONG_EQ:     match = (value == cfg.long_thr);
            kpc_pkg::CMP_DOUBLE_LONG: match = (sum >= {1'b0, cfg.long_thr});
            default:                  match = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/kpc_seq.sv
// ----------------------------------------------------------------------------
// kpc_seq
// sequencer: walks the columns of a sample, updates the counter store and
// searches it through the shared comparator, queues events to the output
// ----------------------------------------------------------------------------
module kpc_seq #(
    parameter int ROWS = kpc_pkg::ROWS_DEF,
    parameter int COLS = kpc_pkg::COLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  kpc_pkg::cfg_t                      cfg,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_row,
    input  logic [kpc_pkg::LEVEL_W-1:0]        s_column_levels,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [kpc_pkg::KIND_W-1:0]         m_event_kind,
    output logic [kpc_pkg::KEY_OUT_W-1:0]      m_first_key,
    output logic [kpc_pkg::KEY_OUT_W-1:0]      m_second_key,
    output logic                               m_last
);

    localparam int KEYS = ROWS * COLS;
    localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int JW   = $clog2(KEYS + 1);
    localparam int NCOL = (COLS < kpc_pkg::LEVEL_W) ? COLS : kpc_pkg::LEVEL_W;
    localparam int CW   = kpc_pkg::COUNT_W;
    localparam int OW   = kpc_pkg::KEY_OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_SRCH,
        ST_EMIT,
        ST_NEXT,
        ST_FLUSH
    } state_t;

    state_t                           state_reg;
    logic [1:0]                       col_reg;
    logic [kpc_pkg::LEVEL_W-1:0]      levels_reg;
    logic [KW-1:0]                    key_reg;
    logic [JW-1:0]                    j_reg;
    logic [KW-1:0]                    jd_reg;
    logic                             dv_reg;
    logic                             dvld_reg;
    logic [KEYS-1:0]                  vld_reg;
    kpc_pkg::cmp_op_t                 mode_reg;
    logic [kpc_pkg::KIND_W-1:0]       evt_kind_reg;
    logic [KW-1:0]                    evt_other_reg;
    logic                             pend_valid_reg;
    logic [kpc_pkg::KIND_W-1:0]       pend_kind_reg;
    logic [OW-1:0]                    pend_first_reg;
    logic [OW-1:0]                    pend_second_reg;
    logic                             out_valid_reg;
    logic [kpc_pkg::KIND_W-1:0]       out_kind_reg;
    logic [OW-1:0]                    out_first_reg;
    logic [OW-1:0]                    out_second_reg;
    logic                             out_last_reg;

    logic [KW-1:0]                    rd_addr;
    logic [CW-1:0]                    rd_data;
    logic                             wr_en;
    logic [CW-1:0]                    cnt;
    logic [CW-1:0]                    cnt_inc;
    logic                             pressed;
    logic [CW-1:0]                    cmp_value;
    kpc_pkg::cmp_op_t                 cmp_op;
    logic                             cmp_match;
    logic                             hit;
    logic                             out_free;
    logic                             out_load;
    logic [KW+OW-1:0]                 key_ext;
    logic [KW+OW-1:0]                 other_ext;

    assign rd_addr   = (state_reg == ST_SRCH) ? j_reg[KW-1:0] : key_reg;
    assign cnt       = dvld_reg ? rd_data : '0;
    assign cnt_inc   = cnt + 1'b1;
    assign pressed   = ~levels_reg[col_reg];
    assign wr_en     = (state_reg == ST_CHK) && pressed && (cnt != kpc_pkg::COUNT_MAX);
    assign cmp_value = ((state_reg == ST_CHK) && pressed) ? cnt_inc : cnt;
    assign cmp_op    = (state_reg == ST_CHK) ?
                       (pressed ? kpc_pkg::CMP_LONG_EQ : kpc_pkg::CMP_SHORT) : mode_reg;
    assign hit       = dv_reg && (jd_reg != key_reg) && cmp_match;
    assign out_free  = ~out_valid_reg | m_ready;
    assign out_load  = pend_valid_reg && out_free &&
                       ((state_reg == ST_EMIT) || (state_reg == ST_FLUSH));
    assign key_ext   = {{OW{1'b0}}, key_reg};
    assign other_ext = {{OW{1'b0}}, evt_other_reg};

    kpc_ram #(
        .WIDTH (CW),
        .DEPTH (KEYS),
        .AW    (KW)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (key_reg),
        .wdata (cnt_inc),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    kpc_cmp u_cmp (
        .value (cmp_value),
        .op    (cmp_op),
        .cfg   (cfg),
        .match (cmp_match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            vld_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            dv_reg         <= 1'b0;
            dvld_reg       <= 1'b0;
        end else begin
            dvld_reg <= vld_reg[rd_addr];
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && (int'(s_row) < ROWS)) begin
                        levels_reg <= s_column_levels;
                        key_reg    <= KW'(int'(s_row) * COLS);
                        col_reg    <= '0;
                        state_reg  <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    j_reg  <= '0;
                    dv_reg <= 1'b0;
                    if (pressed) begin
                        if (wr_en) begin
                            vld_reg[key_reg] <= 1'b1;
                        end
                        if (wr_en && cmp_match) begin
                            mode_reg  <= kpc_pkg::CMP_DOUBLE_LONG;
                            state_reg <= ST_SRCH;
                        end else begin
                            state_reg <= ST_NEXT;
                        end
                    end else begin
                        vld_reg[key_reg] <= 1'b0;
                        if (cmp_match) begin
                            mode_reg  <= kpc_pkg::CMP_SHORT;
                            state_reg <= ST_SRCH;
                        end else begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_SRCH: begin
                    if (hit) begin
                        evt_other_reg <= jd_reg;
                        if (mode_reg == kpc_pkg::CMP_SHORT) begin
                            evt_kind_reg    <= kpc_pkg::EV_DOUBLE_SHORT;
                            vld_reg[jd_reg] <= 1'b0;
                        end else begin
                            evt_kind_reg <= kpc_pkg::EV_DOUBLE_LONG;
                        end
                        state_reg <= ST_EMIT;
                    end else if (!dv_reg && (j_reg == JW'(KEYS))) begin
                        evt_other_reg <= key_reg;
                        evt_kind_reg  <= (mode_reg == kpc_pkg::CMP_SHORT) ?
                                         kpc_pkg::EV_SHORT : kpc_pkg::EV_LONG;
                        state_reg     <= ST_EMIT;
                    end else begin
                        dv_reg <= (j_reg < JW'(KEYS));
                        jd_reg <= j_reg[KW-1:0];
                        if (j_reg < JW'(KEYS)) begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            out_kind_reg   <= pend_kind_reg;
                            out_first_reg  <= pend_first_reg;
                            out_second_reg <= pend_second_reg;
                            out_last_reg   <= 1'b0;
                        end
                        pend_valid_reg  <= 1'b1;
                        pend_kind_reg   <= evt_kind_reg;
                        pend_first_reg  <= key_ext[OW-1:0];
                        pend_second_reg <= other_ext[OW-1:0];
                        state_reg       <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (col_reg == 2'(NCOL - 1)) begin
                        state_reg <= ST_FLUSH;
                    end else begin
                        col_reg   <= col_reg + 1'b1;
                        key_reg   <= key_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_FLUSH: begin
                    if (!pend_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        out_kind_reg   <= pend_kind_reg;
                        out_first_reg  <= pend_first_reg;
                        out_second_reg <= pend_second_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_event_kind = out_kind_reg;
    assign m_first_key  = out_first_reg;
    assign m_second_key = out_second_reg;
    assign m_last       = out_last_reg;

endmodule

// File: hw/rtl/kpc_checker.sv
// ----------------------------------------------------------------------------
// kpc_checker
// port-level checks of the keypad press classifier, bound to the top level
// ----------------------------------------------------------------------------
module kpc_checker #(
    parameter int ROWS = kpc_pkg::ROWS_DEF,
    parameter int COLS = kpc_pkg::COLS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [1:0]                     s_row,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [kpc_pkg::KIND_W-1:0]     m_event_kind,
    input logic [kpc_pkg::KEY_OUT_W-1:0]  m_first_key,
    input logic [kpc_pkg::KEY_OUT_W-1:0]  m_second_key,
    input logic                           m_last
);

    localparam bit KEYS_FIT = (ROWS * COLS) <= (1 << kpc_pkg::KEY_OUT_W);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) &&
        $stable(m_first_key) && $stable(m_second_key) && $stable(m_last))
        else $error("result changed while stalled");

    // a valid sample is worked on before the next is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (int'(s_row) < ROWS) |=> !s_ready)
        else $error("sample taken while busy");

    // single events name one key
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == kpc_pkg::EV_SHORT ||
        m_event_kind == kpc_pkg::EV_LONG) |-> m_second_key == m_first_key)
        else $error("single event with two keys");

    // double events name two keys
    a_double: assert property (@(posedge aclk) disable iff (!aresetn)
        KEYS_FIT && m_valid && (m_event_kind == kpc_pkg::EV_DOUBLE_SHORT ||
        m_event_kind == kpc_pkg::EV_DOUBLE_LONG) |-> m_second_key != m_first_key)
        else $error("double event with one key");

    // no new sample is taken while an event other than the final one of a sample waits
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("ready while events of a sample are pending");

endmodule

bind keypad_press_classifier kpc_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_kpc_checker (.*);

// File: sim/kpc_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kpc_event_checker
// watches the configuration, sample and event channels of the keypad press
// classifier, keeps its own per-key press counters and register copy, works
// out the events each accepted sample must give and compares every accepted
// event in order against them
// ----------------------------------------------------------------------------
module kpc_event_checker #(
    parameter int ROWS = kpc_pkg::ROWS_DEF,
    parameter int COLS = kpc_pkg::COLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [kpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kpc_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [1:0]                    s_row,
    input  logic [kpc_pkg::LEVEL_W-1:0]   s_column_levels,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [kpc_pkg::KIND_W-1:0]    m_event_kind,
    input  logic [kpc_pkg::KEY_OUT_W-1:0] m_first_key,
    input  logic [kpc_pkg::KEY_OUT_W-1:0] m_second_key,
    input  logic                          m_last,
    output int                            error_count,
    output int                            events_pending
);
    import kpc_pkg::*;

    localparam int KEYS = ROWS * COLS;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [KEY_OUT_W-1:0] first_key;
        logic [KEY_OUT_W-1:0] second_key;
        logic                 last;
    } press_event_t;

    press_event_t       expected_events[$];
    logic [COUNT_W-1:0] key_counts [KEYS];
    cfg_t               regs;
    int                 mismatches;

    initial begin
        error_count    = 0;
        events_pending = 0;
        mismatches     = 0;
    end

    function automatic bit in_short_window(input logic [COUNT_W-1:0] count);
        return count != '0 && count < regs.short_thr;
    endfunction

    function automatic press_event_t make_event(input logic [KIND_W-1:0] kind,
                                                input int first, input int second);
        press_event_t ev;
        ev.kind       = kind;
        ev.first_key  = KEY_OUT_W'(first);
        ev.second_key = KEY_OUT_W'(second);
        ev.last       = 1'b0;
        return ev;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 200) begin
            $display("%0t: event mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic classify_sample(input logic [1:0] row, input logic [LEVEL_W-1:0] levels);
        int           key;
        int           other;
        int           limit;
        int           first_new;
        bit           found;
        press_event_t ev;
        first_new = expected_events.size();
        if (int'(row) < ROWS) begin
            for (int c = 0; c < COLS && c < LEVEL_W; c++) begin
                key   = int'(row) * COLS + c;
                other = key;
                found = 1'b0;
                if (!levels[c]) begin
                    if (key_counts[key] != COUNT_MAX) begin
                        key_counts[key] = key_counts[key] + 1'b1;
                        if (key_counts[key] == regs.long_thr) begin
                            limit = int'(regs.long_thr) - int'(regs.long_dev);
                            for (int j = 0; j < KEYS; j++) begin
                                if (!found && j != key && int'(key_counts[j]) >= limit) begin
                                    found = 1'b1;
                                    other = j;
                                end
                            end
                            expected_events.push_back(make_event(
                                found ? EV_DOUBLE_LONG : EV_LONG, key, other));
                        end
                    end
                end else begin
                    if (in_short_window(key_counts[key])) begin
                        for (int j = 0; j < KEYS; j++) begin
                            if (!found && j != key && in_short_window(key_counts[j])) begin
                                found = 1'b1;
                                other = j;
                            end
                        end
                        expected_events.push_back(make_event(
                            found ? EV_DOUBLE_SHORT : EV_SHORT, key, other));
                        key_counts[other] = '0;
                    end
                    key_counts[key] = '0;
                end
            end
        end
        // mark the final event of this sample
        if (expected_events.size() > first_new) begin
            ev      = expected_events.pop_back();
            ev.last = 1'b1;
            expected_events.push_back(ev);
        end
    endtask

    always @(posedge aclk) begin
        press_event_t want;
        if (!aresetn) begin
            for (int k = 0; k < KEYS; k++) begin
                key_counts[k] = '0;
            end
            regs.long_thr  = LONG_THR_RST;
            regs.short_thr = SHORT_THR_RST;
            regs.long_dev  = LONG_DEV_RST;
            expected_events.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LONG_THR: begin
                        regs.long_thr = cfg_data;
                    end
                    CFG_SHORT_THR: begin
                        regs.short_thr = cfg_data;
                    end
                    CFG_LONG_DEV: begin
                        regs.long_dev = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event kind %0d keys %0d/%0d last %0d",
                        m_event_kind, m_first_key, m_second_key, m_last));
                end else begin
                    want = expected_events.pop_front();
                    if (m_event_kind !== want.kind || m_first_key !== want.first_key ||
                        m_second_key !== want.second_key || m_last !== want.last) begin
                        report_mismatch($sformatf(
                            "got kind %0d keys %0d/%0d last %0d, want kind %0d keys %0d/%0d last %0d",
                            m_event_kind, m_first_key, m_second_key, m_last,
                            want.kind, want.first_key, want.second_key, want.last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                classify_sample(s_row, s_column_levels);
            end
        end
        events_pending <= expected_events.size();
        error_count    <= mismatches;
    end

endmodule

// File: sim/tb_keypad_press_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keypad_press_classifier
// drives scan samples and register writes into the keypad press classifier:
// a short directed run over every event kind, then random press and release
// gestures under several register settings, with bursty requests and random
// event stalls; the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_keypad_press_classifier;
    import kpc_pkg::*;

    localparam int ROWS          = ROWS_DEF;
    localparam int COLS          = COLS_DEF;
    localparam int KEYS          = ROWS * COLS;
    localparam int CLK_PERIOD    = 10;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 64;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = CFG_LONG_THR;
    logic [COUNT_W-1:0]   cfg_data        = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_row           = '0;
    logic [LEVEL_W-1:0]   s_column_levels = '1;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [KIND_W-1:0]    m_event_kind;
    logic [KEY_OUT_W-1:0] m_first_key;
    logic [KEY_OUT_W-1:0] m_second_key;
    logic                 m_last;

    int              error_count;
    int              events_pending;
    int              idle_cycles = 0;
    int              max_gap     = 0;
    int              max_stall   = 0;
    int              burst_left  = 0;
    int              stall_left  = 0;
    logic [KEYS-1:0] held_keys   = '0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    keypad_press_classifier #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row           (s_row),
        .s_column_levels (s_column_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_first_key     (m_first_key),
        .m_second_key    (m_second_key),
        .m_last          (m_last)
    );

    kpc_event_checker #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row           (s_row),
        .s_column_levels (s_column_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_first_key     (m_first_key),
        .m_second_key    (m_second_key),
        .m_last          (m_last),
        .error_count     (error_count),
        .events_pending  (events_pending)
    );

    // event receiver stalls
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (max_stall > 0 && $urandom_range(0, 3) == 0) begin
                stall_left <= $urandom_range(1, max_stall);
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_sample(input logic [1:0] row, input logic [LEVEL_W-1:0] levels);
        int gap;
        if (burst_left == 0) begin
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_row           <= row;
        s_column_levels <= levels;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic write_config(input logic [COUNT_W-1:0] long_thr,
                                input logic [COUNT_W-1:0] short_thr,
                                input logic [COUNT_W-1:0] long_dev);
        push_reg(CFG_LONG_THR, long_thr);
        push_reg(CFG_SHORT_THR, short_thr);
        push_reg(CFG_LONG_DEV, long_dev);
        cfg_valid <= 1'b0;
    endtask

    // let every outstanding event out, then allow the last sample to finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (events_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random press and release gestures of up to two keys, with some noise
    task automatic run_gestures(input int items, input int gap_max, input int stall_max);
        int                 k;
        logic [1:0]         row;
        logic [LEVEL_W-1:0] levels;
        max_gap   = gap_max;
        max_stall = stall_max;
        repeat (items) begin
            if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(0, KEYS - 1);
                if ($urandom_range(0, 1) == 0 && held_keys != '0) begin
                    while (!held_keys[k]) k = (k + 1) % KEYS;
                    held_keys[k] = 1'b0;
                end else if ($countones(held_keys) < 2) begin
                    held_keys[k] = 1'b1;
                end
            end
            if (held_keys != '0 && $urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, KEYS - 1);
                while (!held_keys[k]) k = (k + 1) % KEYS;
                row = 2'(k / COLS);
            end else begin
                row = 2'($urandom_range(0, ROWS - 1));
            end
            levels = '1;
            for (int c = 0; c < COLS && c < LEVEL_W; c++) begin
                levels[c] = ~held_keys[int'(row) * COLS + c];
            end
            if ($urandom_range(0, 7) == 0) begin
                levels = LEVEL_W'($urandom_range(0, (1 << LEVEL_W) - 1));
            end
            put_sample(row, levels);
        end
    endtask

    // key 3 held throughout until its counter sticks at the top
    task automatic hold_to_saturation(input int items);
        max_gap   = 4;
        max_stall = 5;
        repeat (items) begin
            put_sample(2'd1, {2'($urandom_range(0, 3)), 1'b0});
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: short and double short
        repeat (3) put_sample(2'd0, 3'b110);
        put_sample(2'd0, 3'b111);
        repeat (2) put_sample(2'd1, 3'b100);
        put_sample(2'd1, 3'b111);
        repeat (2) put_sample(2'd3, 3'b000);
        put_sample(2'd3, 3'b111);
        settle();

        // long and double long, three events from one sample, no short window
        write_config(8'd2, 8'd1, 8'd0);
        repeat (2) put_sample(2'd2, 3'b110);
        repeat (2) put_sample(2'd2, 3'b100);
        put_sample(2'd2, 3'b111);
        repeat (2) put_sample(2'd0, 3'b000);
        put_sample(2'd0, 3'b111);
        settle();

        write_config(8'd4, 8'd4, 8'd1);
        run_gestures(10, 6, 0);
        settle();

        write_config(8'($urandom_range(3, 8)), 8'($urandom_range(2, 8)),
                     8'($urandom_range(0, 4)));
        run_gestures(10, 0, 20);
        settle();

        // zero thresholds never report anything
        write_config(8'd0, 8'd0, 8'($urandom_range(0, 255)));
        run_gestures(6, 10, 8);
        settle();

        // deviation beyond threshold lets any other key pair up
        write_config(8'd1, 8'd255, 8'd255);
        run_gestures(10, 3, 30);
        settle();

        write_config(8'd255, 8'($urandom_range(4, 16)), 8'($urandom_range(0, 255)));
        hold_to_saturation(256);
        settle();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_ram.sv
hw/rtl/kpc_cmp.sv
hw/rtl/kpc_seq.sv
hw/rtl/keypad_press_classifier.sv
hw/rtl/kpc_checker.sv
sim/kpc_event_checker.sv
sim/tb_keypad_press_classifier.sv
